/* hdl/ggpc_pkg.sv */
// Shared types, constants and codes for the greedy grid point clusterer.
package ggpc_pkg;

    localparam int MAX_CLUSTERS = 64;
    localparam int MAX_MEMB     = 256;
    localparam int CID_W        = $clog2(MAX_CLUSTERS);
    localparam int CU_W         = $clog2(MAX_CLUSTERS + 1);
    localparam int MIDX_W       = $clog2(MAX_MEMB);
    localparam int MU_W         = $clog2(MAX_MEMB + 1);

    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 24;
    localparam int TAG_W    = 31;
    localparam int SUM_W    = 48;
    localparam int CNT_W    = 16;
    localparam int DIV_W    = 48;
    localparam int DVSR_W   = 32;
    localparam int ACC_W    = 98;

    localparam int MEMB_W = 2 * COORD_W + CID_W;
    localparam int CLU_W  = 2 * SUM_W + CNT_W;

    localparam logic              KIND_POINT  = 1'b0;
    localparam logic              KIND_FLUSH  = 1'b1;
    localparam logic [CNT_W-1:0]  COUNT_LIMIT = 16'hFFFF;
    localparam logic [3:0]        NO_HIT      = 4'd15;
    localparam logic [3:0]        CENTER_K    = 4'd4;
    localparam logic [COORD_W-1:0] GRID_MAX   = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_JOINED = 3'd0,
        ST_NEW    = 3'd1,
        ST_REJECT = 3'd2,
        ST_REPORT = 3'd3,
        ST_EMPTY  = 3'd4
    } status_t;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [TAG_W-1:0]   tag;
        logic [COORD_W-1:0] gx;
        logic [COORD_W-1:0] gy;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic [CID_W-1:0]   cid;
        logic [TAG_W-1:0]   tag;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [CNT_W-1:0]   cnt;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [CU_W-1:0] clusters;
        logic [MU_W-1:0] cells;
    } occ_t;

    typedef enum logic [1:0] {
        F_EMPTY,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_M_RD,
        B_M_CHK,
        B_D_N,
        B_D_MUL,
        B_D_DIFF,
        B_D_SQ,
        B_D_CMP,
        B_DECIDE,
        B_U_RD,
        B_UPD,
        B_EMIT,
        B_F_RD,
        B_F_DIV,
        B_F_WAIT,
        B_F_NEXT
    } back_state_t;

endpackage

/* hdl/ggpc_ram.sv */
// Generic simple dual-port RAM with registered read.
module ggpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/ggpc_div.sv */
// Restoring divider, one quotient bit per cycle.
module ggpc_div
    import ggpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DVSR_W-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [DIV_W-1:0]  quotient
);

    localparam int STEP_W = $clog2(DIV_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [DVSR_W-1:0] rem_reg, rem_next;
    logic [DVSR_W-1:0] dvsr_reg, dvsr_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DVSR_W:0]   trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dvsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvsr_next = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DVSR_W'(trial - {1'b0, dvsr_reg}) : trial[DVSR_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
        quo_reg  <= quo_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hdl/ggpc_queue.sv */
// Two-entry queue between the front and back parts.
module ggpc_queue
    import ggpc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t pop_item,
    output logic  empty
);

    item_t      ent_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full     = cnt_reg == 2'd2;
    assign empty    = cnt_reg == 2'd0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = ent_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg ^ do_push;
        rd_next  = rd_reg ^ do_pop;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_reg] <= push_item;
        end
    end

endmodule

/* hdl/ggpc_front.sv */
// Front part: takes input transfers and computes each point's grid cell.
module ggpc_front
    import ggpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  logic [COORD_W-1:0]  pos_x,
    input  logic [COORD_W-1:0]  pos_y,
    input  logic [TAG_W-1:0]    tag,
    input  logic [RADIUS_W-1:0] radius,
    output logic                q_push,
    output item_t               q_item,
    input  logic                q_full
);

    front_state_t state_reg, state_next;
    item_t        item_reg, item_next;
    logic         accept, start;
    logic [DVSR_W-1:0] r_eff;
    logic         busy_x, busy_y, done_x, done_y;
    logic [DIV_W-1:0] qx, qy;

    assign r_eff  = (radius == '0) ? DVSR_W'(1) : DVSR_W'(radius);
    assign accept = in_valid && in_ready;
    assign start  = accept && (kind == KIND_POINT);

    ggpc_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .dividend (DIV_W'(pos_x)),
        .divisor  (r_eff),
        .busy     (busy_x),
        .done     (done_x),
        .quotient (qx)
    );

    ggpc_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .dividend (DIV_W'(pos_y)),
        .divisor  (r_eff),
        .busy     (busy_y),
        .done     (done_y),
        .quotient (qy)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_EMPTY:
            begin
                if (accept)
                begin
                    state_next = (kind == KIND_FLUSH) ? F_PUSH : F_DIV;
                end
            end
            F_DIV:
            begin
                if (done_x && done_y && !busy_x && !busy_y)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_EMPTY;
                end
            end
            default: state_next = F_EMPTY;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        q_push    = 1'b0;
        item_next = item_reg;
        unique case (state_reg)
            F_EMPTY:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    item_next.kind = kind;
                    item_next.px   = pos_x;
                    item_next.py   = pos_y;
                    item_next.tag  = tag;
                    item_next.gx   = '0;
                    item_next.gy   = '0;
                end
            end
            F_DIV:
            begin
                if (done_x)
                begin
                    item_next.gx = qx[COORD_W-1:0];
                    item_next.gy = qy[COORD_W-1:0];
                end
            end
            F_PUSH:
            begin
                q_push = 1'b1;
            end
            default: ;
        endcase
    end

    assign q_item = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

/* hdl/ggpc_back.sv */
// Back part: membership scan, distance test, table update and flush reports.
module ggpc_back
    import ggpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [RADIUS_W-1:0] radius,
    input  logic                q_empty,
    input  item_t               q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output result_t             result,
    output occ_t                occ
);

    localparam logic [CU_W-1:0] CLUS_FULL = CU_W'(MAX_CLUSTERS);
    localparam logic [MU_W-1:0] MEMB_FULL = MU_W'(MAX_MEMB);

    back_state_t state_reg, state_next;
    back_state_t ret_reg, ret_next;

    item_t              cur_reg, cur_next;
    logic [MU_W-1:0]    m_reg, m_next;
    logic [3:0]         best_k_reg, best_k_next;
    logic [CID_W-1:0]   best_own_reg, best_own_next;
    logic [3:0]         cand_k_reg, cand_k_next;
    logic [CID_W-1:0]   cand_own_reg, cand_own_next;
    logic [MAX_CLUSTERS-1:0] seen_reg, seen_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [SUM_W-1:0]   sx_reg, sx_next, sy_reg, sy_next;
    logic [3:0]         step_reg, step_next;
    logic [SUM_W-1:0]   nxp_reg, nxp_next, nyp_reg, nyp_next;
    logic [39:0]        rn_reg, rn_next;
    logic [SUM_W-1:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic [ACC_W-1:0]   lhs_reg, lhs_next, rhs_reg, rhs_next;
    logic [CID_W-1:0]   id_reg, id_next;
    logic               fresh_reg, fresh_next;
    logic               have_reg, have_next;
    logic [CU_W-1:0]    clus_reg, clus_next;
    logic [MU_W-1:0]    cells_reg, cells_next;
    logic [CID_W-1:0]   fk_reg, fk_next;
    result_t            res_reg, res_next;
    result_t            out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic               memb_we;
    logic [MEMB_W-1:0]  memb_rdata;
    logic               clu_we;
    logic [CID_W-1:0]   clu_raddr;
    logic [CLU_W-1:0]   clu_wdata, clu_rdata;

    logic [COORD_W-1:0] mcx, mcy;
    logic [CID_W-1:0]   mown;
    logic [CNT_W-1:0]   rd_n;
    logic [SUM_W-1:0]   rd_sx, rd_sy;

    logic [COORD_W-1:0] r_eff;
    logic               xm, x0, xp, ym, y0, yp, cell_hit;
    logic [3:0]         hit_k;
    logic               try_test;

    logic [COORD_W-1:0] mul_a;
    logic [SUM_W-1:0]   mul_p;
    logic [23:0]        sq_a, sq_b;
    logic [47:0]        sq_p;
    logic [6:0]         sq_sh;
    logic               sq_to_lhs;
    logic [ACC_W-1:0]   sq_term;

    logic               fresh_now, rej_fresh, rej_join, last_k, slot_free;
    logic               div_start, busy_x, busy_y, done_x, done_y;
    logic [DIV_W-1:0]   qx, qy;

    ggpc_ram #(.WIDTH(MEMB_W), .DEPTH(MAX_MEMB)) u_memb_ram (
        .clk   (clk),
        .we    (memb_we),
        .waddr (cells_reg[MIDX_W-1:0]),
        .wdata ({cur_reg.gx, cur_reg.gy, id_reg}),
        .raddr (m_reg[MIDX_W-1:0]),
        .rdata (memb_rdata)
    );

    ggpc_ram #(.WIDTH(CLU_W), .DEPTH(MAX_CLUSTERS)) u_clu_ram (
        .clk   (clk),
        .we    (clu_we),
        .waddr (id_reg),
        .wdata (clu_wdata),
        .raddr (clu_raddr),
        .rdata (clu_rdata)
    );

    ggpc_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd_sx),
        .divisor  (DVSR_W'(rd_n)),
        .busy     (busy_x),
        .done     (done_x),
        .quotient (qx)
    );

    ggpc_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd_sy),
        .divisor  (DVSR_W'(rd_n)),
        .busy     (busy_y),
        .done     (done_y),
        .quotient (qy)
    );

    assign {mcx, mcy, mown}   = memb_rdata;
    assign {rd_sx, rd_sy, rd_n} = clu_rdata;
    assign r_eff = (radius == '0) ? COORD_W'(1) : COORD_W'(radius);

    // Neighbor cell match, ordered dx outer then dy inner
    always_comb
    begin
        xm = (cur_reg.gx != '0) && (mcx == cur_reg.gx - 1'b1);
        x0 = mcx == cur_reg.gx;
        xp = (cur_reg.gx != GRID_MAX) && (mcx == cur_reg.gx + 1'b1);
        ym = (cur_reg.gy != '0) && (mcy == cur_reg.gy - 1'b1);
        y0 = mcy == cur_reg.gy;
        yp = (cur_reg.gy != GRID_MAX) && (mcy == cur_reg.gy + 1'b1);
        cell_hit = (xm || x0 || xp) && (ym || y0 || yp);
        hit_k = (xm ? 4'd0 : (x0 ? 4'd3 : 4'd6)) + (ym ? 4'd0 : (y0 ? 4'd1 : 4'd2));
        try_test = cell_hit && (hit_k < best_k_reg) && ({1'b0, mown} < clus_reg);
    end

    // One 32x16 multiplier for n*px, n*py and n*radius
    always_comb
    begin
        case (step_reg)
            4'd0:    mul_a = cur_reg.px;
            4'd1:    mul_a = cur_reg.py;
            default: mul_a = r_eff;
        endcase
        mul_p = {16'b0, mul_a} * {32'b0, n_reg};
    end

    // One 24x24 multiplier for the squares, summed over nine steps
    always_comb
    begin
        sq_to_lhs = 1'b1;
        case (step_reg)
            4'd0:    begin sq_a = dx_reg[47:24]; sq_b = dx_reg[47:24]; sq_sh = 7'd48; end
            4'd1:    begin sq_a = dx_reg[47:24]; sq_b = dx_reg[23:0];  sq_sh = 7'd25; end
            4'd2:    begin sq_a = dx_reg[23:0];  sq_b = dx_reg[23:0];  sq_sh = 7'd0;  end
            4'd3:    begin sq_a = dy_reg[47:24]; sq_b = dy_reg[47:24]; sq_sh = 7'd48; end
            4'd4:    begin sq_a = dy_reg[47:24]; sq_b = dy_reg[23:0];  sq_sh = 7'd25; end
            4'd5:    begin sq_a = dy_reg[23:0];  sq_b = dy_reg[23:0];  sq_sh = 7'd0;  end
            4'd6:
            begin
                sq_a = {8'b0, rn_reg[39:24]}; sq_b = {8'b0, rn_reg[39:24]};
                sq_sh = 7'd48; sq_to_lhs = 1'b0;
            end
            4'd7:
            begin
                sq_a = {8'b0, rn_reg[39:24]}; sq_b = rn_reg[23:0];
                sq_sh = 7'd25; sq_to_lhs = 1'b0;
            end
            default:
            begin
                sq_a = rn_reg[23:0]; sq_b = rn_reg[23:0];
                sq_sh = 7'd0; sq_to_lhs = 1'b0;
            end
        endcase
        sq_p    = sq_a * sq_b;
        sq_term = {{(ACC_W-48){1'b0}}, sq_p} << sq_sh;
    end

    assign fresh_now = best_k_reg == NO_HIT;
    assign rej_fresh = (clus_reg >= CLUS_FULL) || (cells_reg >= MEMB_FULL);
    assign rej_join  = (rd_n >= COUNT_LIMIT)
                       || (!seen_reg[best_own_reg] && (cells_reg >= MEMB_FULL));
    assign last_k    = ({1'b0, fk_reg} + 1'b1) == clus_reg;
    assign slot_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_item.kind == KIND_FLUSH)
                    begin
                        state_next = (clus_reg == '0) ? B_EMIT : B_F_RD;
                    end
                    else
                    begin
                        state_next = B_M_RD;
                    end
                end
            end
            B_M_RD:   state_next = (m_reg == cells_reg) ? B_DECIDE : B_M_CHK;
            B_M_CHK:  state_next = try_test ? B_D_N : B_M_RD;
            B_D_N:    state_next = B_D_MUL;
            B_D_MUL:  state_next = (step_reg == 4'd2) ? B_D_DIFF : B_D_MUL;
            B_D_DIFF: state_next = B_D_SQ;
            B_D_SQ:   state_next = (step_reg == 4'd8) ? B_D_CMP : B_D_SQ;
            B_D_CMP:  state_next = B_M_RD;
            B_DECIDE:
            begin
                if (fresh_now)
                begin
                    state_next = rej_fresh ? B_EMIT : B_UPD;
                end
                else
                begin
                    state_next = B_U_RD;
                end
            end
            B_U_RD:   state_next = rej_join ? B_EMIT : B_UPD;
            B_UPD:    state_next = B_EMIT;
            B_EMIT:   state_next = slot_free ? ret_reg : B_EMIT;
            B_F_RD:   state_next = B_F_DIV;
            B_F_DIV:  state_next = B_F_WAIT;
            B_F_WAIT:
            begin
                if (done_x && done_y && !busy_x && !busy_y)
                begin
                    state_next = B_EMIT;
                end
            end
            B_F_NEXT: state_next = res_reg.last ? B_IDLE : B_F_RD;
            default:  state_next = B_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        ret_next       = ret_reg;
        cur_next       = cur_reg;
        m_next         = m_reg;
        best_k_next    = best_k_reg;
        best_own_next  = best_own_reg;
        cand_k_next    = cand_k_reg;
        cand_own_next  = cand_own_reg;
        seen_next      = seen_reg;
        n_next         = n_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        step_next      = step_reg;
        nxp_next       = nxp_reg;
        nyp_next       = nyp_reg;
        rn_next        = rn_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        lhs_next       = lhs_reg;
        rhs_next       = rhs_reg;
        id_next        = id_reg;
        fresh_next     = fresh_reg;
        have_next      = have_reg;
        clus_next      = clus_reg;
        cells_next     = cells_reg;
        fk_next        = fk_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        q_pop          = 1'b0;
        memb_we        = 1'b0;
        clu_we         = 1'b0;
        clu_raddr      = fk_reg;
        clu_wdata      = {SUM_W'(sx_reg + SUM_W'(cur_reg.px)),
                          SUM_W'(sy_reg + SUM_W'(cur_reg.py)),
                          CNT_W'(n_reg + 1'b1)};
        div_start      = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop       = 1'b1;
                    cur_next    = q_item;
                    m_next      = '0;
                    best_k_next = NO_HIT;
                    seen_next   = '0;
                    fk_next     = '0;
                    if (q_item.kind == KIND_FLUSH)
                    begin
                        res_next        = '0;
                        res_next.status = ST_EMPTY;
                        res_next.last   = 1'b1;
                        ret_next        = (clus_reg == '0) ? B_IDLE : B_F_NEXT;
                    end
                    else
                    begin
                        ret_next = B_IDLE;
                    end
                end
            end
            B_M_CHK:
            begin
                if (x0 && y0)
                begin
                    seen_next[mown] = 1'b1;
                end
                if (try_test)
                begin
                    clu_raddr     = mown;
                    cand_k_next   = hit_k;
                    cand_own_next = mown;
                end
                else
                begin
                    m_next = m_reg + 1'b1;
                end
            end
            B_D_N:
            begin
                n_next    = rd_n;
                sx_next   = rd_sx;
                sy_next   = rd_sy;
                step_next = '0;
            end
            B_D_MUL:
            begin
                case (step_reg)
                    4'd0:    nxp_next = mul_p;
                    4'd1:    nyp_next = mul_p;
                    default: rn_next  = mul_p[39:0];
                endcase
                step_next = step_reg + 1'b1;
            end
            B_D_DIFF:
            begin
                dx_next   = (nxp_reg >= sx_reg) ? nxp_reg - sx_reg : sx_reg - nxp_reg;
                dy_next   = (nyp_reg >= sy_reg) ? nyp_reg - sy_reg : sy_reg - nyp_reg;
                lhs_next  = '0;
                rhs_next  = '0;
                step_next = '0;
            end
            B_D_SQ:
            begin
                if (sq_to_lhs)
                begin
                    lhs_next = lhs_reg + sq_term;
                end
                else
                begin
                    rhs_next = rhs_reg + sq_term;
                end
                step_next = step_reg + 1'b1;
            end
            B_D_CMP:
            begin
                if (lhs_reg <= rhs_reg)
                begin
                    best_k_next   = cand_k_reg;
                    best_own_next = cand_own_reg;
                end
                m_next = m_reg + 1'b1;
            end
            B_DECIDE:
            begin
                fresh_next = fresh_now;
                clu_raddr  = best_own_reg;
                res_next        = '0;
                res_next.status = ST_REJECT;
                res_next.tag    = cur_reg.tag;
                res_next.last   = 1'b1;
                if (fresh_now)
                begin
                    id_next   = clus_reg[CID_W-1:0];
                    have_next = 1'b0;
                    n_next    = '0;
                    sx_next   = '0;
                    sy_next   = '0;
                end
                else
                begin
                    id_next = best_own_reg;
                end
            end
            B_U_RD:
            begin
                n_next    = rd_n;
                sx_next   = rd_sx;
                sy_next   = rd_sy;
                have_next = seen_reg[best_own_reg];
            end
            B_UPD:
            begin
                clu_we  = 1'b1;
                memb_we = !have_reg;
                if (!have_reg)
                begin
                    cells_next = cells_reg + 1'b1;
                end
                if (fresh_reg)
                begin
                    clus_next = clus_reg + 1'b1;
                end
                res_next.status = fresh_reg ? ST_NEW : ST_JOINED;
                res_next.cid    = id_reg;
                res_next.cnt    = CNT_W'(n_reg + 1'b1);
            end
            B_EMIT:
            begin
                if (slot_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    if (res_reg.status == ST_EMPTY)
                    begin
                        clus_next  = '0;
                        cells_next = '0;
                    end
                end
            end
            B_F_RD:
            begin
                clu_raddr = fk_reg;
            end
            B_F_DIV:
            begin
                div_start = 1'b1;
                n_next    = rd_n;
            end
            B_F_WAIT:
            begin
                res_next.status = ST_REPORT;
                res_next.cid    = fk_reg;
                res_next.tag    = '0;
                res_next.cx     = (n_reg == '0) ? '0 : qx[COORD_W-1:0];
                res_next.cy     = (n_reg == '0) ? '0 : qy[COORD_W-1:0];
                res_next.cnt    = n_reg;
                res_next.last   = last_k;
                ret_next        = B_F_NEXT;
            end
            B_F_NEXT:
            begin
                if (res_reg.last)
                begin
                    clus_next  = '0;
                    cells_next = '0;
                end
                else
                begin
                    fk_next = fk_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            ret_reg       <= B_IDLE;
            clus_reg      <= '0;
            cells_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            clus_reg      <= clus_next;
            cells_reg     <= cells_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        m_reg        <= m_next;
        best_k_reg   <= best_k_next;
        best_own_reg <= best_own_next;
        cand_k_reg   <= cand_k_next;
        cand_own_reg <= cand_own_next;
        seen_reg     <= seen_next;
        n_reg        <= n_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        step_reg     <= step_next;
        nxp_reg      <= nxp_next;
        nyp_reg      <= nyp_next;
        rn_reg       <= rn_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        lhs_reg      <= lhs_next;
        rhs_reg      <= rhs_next;
        id_reg       <= id_next;
        fresh_reg    <= fresh_next;
        have_reg     <= have_next;
        fk_reg       <= fk_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    assign out_valid      = out_valid_reg;
    assign result         = out_reg;
    assign occ.clusters   = clus_reg;
    assign occ.cells      = cells_reg;

endmodule

/* hdl/greedy_grid_point_clusterer.sv */
// Point: a grid-cell divide, then a scan of every stored membership entry, with
// a distance test for each neighbor entry that needs one, then the table
// update; a 32x16 and a 24x24 multiplier carry the distance test.
// Flush: one report per cluster, or one empty report if there are none; two 48-step dividers take each centroid.
// Reset clears the cluster and membership counts; the tables are not swept.
module greedy_grid_point_clusterer
    import ggpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  logic [COORD_W-1:0]  pos_x,
    input  logic [COORD_W-1:0]  pos_y,
    input  logic [TAG_W-1:0]    tag,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          status,
    output logic [CID_W-1:0]    cluster_id,
    output logic [TAG_W-1:0]    tag_out,
    output logic [COORD_W-1:0]  centre_x,
    output logic [COORD_W-1:0]  centre_y,
    output logic [CNT_W-1:0]    member_count,
    output logic                last
);

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd10240;

    logic [RADIUS_W-1:0] radius_reg, radius_next;
    logic    q_push, q_full, q_pop, q_empty;
    item_t   q_in, q_out;
    result_t res;
    occ_t    occ;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? 32'(radius_reg) : '0;

    always_comb
    begin
        radius_next = radius_reg;
        if (psel && penable && pwrite && (paddr[2] == 1'b0))
        begin
            radius_next = pwdata[RADIUS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else
        begin
            radius_reg <= radius_next;
        end
    end

    ggpc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .tag      (tag),
        .radius   (radius_reg),
        .q_push   (q_push),
        .q_item   (q_in),
        .q_full   (q_full)
    );

    ggpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_out),
        .empty     (q_empty)
    );

    ggpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .radius    (radius_reg),
        .q_empty   (q_empty),
        .q_item    (q_out),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (res),
        .occ       (occ)
    );

    assign status       = res.status;
    assign cluster_id   = res.cid;
    assign tag_out      = res.tag;
    assign centre_x     = res.cx;
    assign centre_y     = res.cy;
    assign member_count = res.cnt;
    assign last         = res.last;

    a_clusters_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ.clusters <= CU_W'(MAX_CLUSTERS))
        else $error("cluster count above table size");

    a_cells_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ.cells <= MU_W'(MAX_MEMB))
        else $error("membership count above table size");

    a_point_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (res.status == ST_JOINED || res.status == ST_NEW
                      || res.status == ST_REJECT || res.status == ST_EMPTY) |-> res.last)
        else $error("single-result transfer without last");

    a_new_grows: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && res.status == ST_NEW |-> occ.clusters == CU_W'(res.cid) + 1'b1)
        else $error("new cluster result does not match cluster count");

endmodule

/* verif/greedy_grid_point_clusterer_tb.sv */
// Self-checking clusterer testbench: directed table, random traffic, then table overflow.
module greedy_grid_point_clusterer_tb;
    import ggpc_pkg::*;

    typedef struct {
        bit                 wr;      // 1: write radius from x instead of sending an item
        logic               kind;
        logic [31:0]        x;
        logic [31:0]        y;
        logic [TAG_W-1:0]   t;
        bit                 typed;   // expected result given in the row
        status_t            st;
        logic [CID_W-1:0]   id;
        logic [CNT_W-1:0]   cnt;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic kind = KIND_POINT;
    logic [COORD_W-1:0] pos_x = '0, pos_y = '0;
    logic [TAG_W-1:0] tag = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] status;
    logic [CID_W-1:0] cluster_id;
    logic [TAG_W-1:0] tag_out;
    logic [COORD_W-1:0] centre_x, centre_y;
    logic [CNT_W-1:0] member_count;
    logic last;

    localparam logic [2:0] ADDR_RADIUS = 3'd0;

    // shadow of the block's tables
    logic [23:0]        cfg_radius;
    logic [SUM_W-1:0]   acc_x [MAX_CLUSTERS];
    logic [SUM_W-1:0]   acc_y [MAX_CLUSTERS];
    logic [CNT_W-1:0]   pop [MAX_CLUSTERS];
    int                 n_clusters;
    logic [31:0]        memb_x [MAX_MEMB];
    logic [31:0]        memb_y [MAX_MEMB];
    int                 memb_own [MAX_MEMB];
    int                 n_cells;

    result_t pending_results[$];
    result_t scratch[$];
    int      errors = 0;
    bit      calm = 1'b0;
    int      stall_left = 0;

    greedy_grid_point_clusterer u_top (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic result_t mk(status_t st, int id, logic [TAG_W-1:0] t,
                                   logic [31:0] cx, logic [31:0] cy,
                                   logic [CNT_W-1:0] cnt, logic lst);
        result_t r;
        r.status = st;
        r.cid = id[CID_W-1:0];
        r.tag = t;
        r.cx = cx;
        r.cy = cy;
        r.cnt = cnt;
        r.last = lst;
        return r;
    endfunction

    function automatic bit near_centroid(int k, logic [31:0] px, logic [31:0] py,
                                         logic [31:0] r);
        logic [63:0]  n, sx, sy, dx, dy, rn;
        logic [127:0] lhs, rhs;
        n = pop[k];
        sx = n * px;
        sy = n * py;
        dx = (sx >= acc_x[k]) ? sx - acc_x[k] : acc_x[k] - sx;
        dy = (sy >= acc_y[k]) ? sy - acc_y[k] : acc_y[k] - sy;
        lhs = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
        rn = 64'(r) * n;
        rhs = 128'(rn) * 128'(rn);
        return lhs <= rhs;
    endfunction

    function automatic void cluster_point(logic k_in, logic [31:0] px, logic [31:0] py,
                                          logic [TAG_W-1:0] t, ref result_t q[$]);
        logic [31:0] r, gx, gy;
        longint nx, ny;
        int found, id, m;
        bit fresh, have;
        if (k_in == KIND_FLUSH)
        begin
            if (n_clusters == 0)
                q.push_back(mk(ST_EMPTY, 0, '0, '0, '0, '0, 1'b1));
            for (int k = 0; k < n_clusters; k++)
                q.push_back(mk(ST_REPORT, k, '0, 32'(acc_x[k] / pop[k]),
                               32'(acc_y[k] / pop[k]), pop[k], k + 1 == n_clusters));
            n_clusters = 0;
            n_cells = 0;
            return;
        end
        r = (cfg_radius == 0) ? 32'd1 : 32'(cfg_radius);
        gx = px / r;
        gy = py / r;
        found = -1;
        for (int ddx = -1; ddx <= 1 && found < 0; ddx++)
        begin
            nx = longint'(gx) + ddx;
            if (nx < 0 || nx > 64'hFFFF_FFFF) continue;
            for (int ddy = -1; ddy <= 1 && found < 0; ddy++)
            begin
                ny = longint'(gy) + ddy;
                if (ny < 0 || ny > 64'hFFFF_FFFF) continue;
                for (m = 0; m < n_cells; m++)
                begin
                    if (memb_x[m] != nx[31:0] || memb_y[m] != ny[31:0]) continue;
                    if (memb_own[m] >= n_clusters) continue;
                    if (near_centroid(memb_own[m], px, py, r))
                    begin
                        found = memb_own[m];
                        break;
                    end
                end
            end
        end
        fresh = found < 0;
        id = fresh ? n_clusters : found;
        if ((fresh && n_clusters >= MAX_CLUSTERS) || (!fresh && pop[id] >= COUNT_LIMIT))
        begin
            q.push_back(mk(ST_REJECT, 0, t, '0, '0, '0, 1'b1));
            return;
        end
        have = 1'b0;
        if (!fresh)
            for (m = 0; m < n_cells; m++)
                if (memb_x[m] == gx && memb_y[m] == gy && memb_own[m] == id)
                begin
                    have = 1'b1;
                    break;
                end
        if (!have && n_cells >= MAX_MEMB)
        begin
            q.push_back(mk(ST_REJECT, 0, t, '0, '0, '0, 1'b1));
            return;
        end
        if (fresh)
        begin
            acc_x[id] = '0;
            acc_y[id] = '0;
            pop[id] = '0;
            n_clusters++;
        end
        acc_x[id] = acc_x[id] + px;
        acc_y[id] = acc_y[id] + py;
        pop[id] = pop[id] + 1'b1;
        if (!have)
        begin
            memb_x[n_cells] = gx;
            memb_y[n_cells] = gy;
            memb_own[n_cells] = id;
            n_cells++;
        end
        q.push_back(mk(fresh ? ST_NEW : ST_JOINED, id, t, '0, '0, pop[id], 1'b1));
    endfunction

    function automatic int pick_gap();
        if (calm) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
        return $urandom_range(10, 40);
    endfunction

    // results side: random back-pressure unless calm, compare every transfer
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result status=%0d id=%0d", status, cluster_id);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, status); errors++;
                end
                if (cluster_id !== e.cid)
                begin
                    $error("cluster_id expected %0d actual %0d", e.cid, cluster_id); errors++;
                end
                if (tag_out !== e.tag)
                begin
                    $error("tag_out expected %h actual %h", e.tag, tag_out); errors++;
                end
                if (centre_x !== e.cx)
                begin
                    $error("centre_x expected %h actual %h", e.cx, centre_x); errors++;
                end
                if (centre_y !== e.cy)
                begin
                    $error("centre_y expected %h actual %h", e.cy, centre_y); errors++;
                end
                if (member_count !== e.cnt)
                begin
                    $error("member_count expected %0d actual %0d", e.cnt, member_count);
                    errors++;
                end
                if (last !== e.last)
                begin
                    $error("last expected %0d actual %0d", e.last, last); errors++;
                end
            end
        end
        if (calm)
        begin
            out_ready <= 1'b1;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            out_ready <= 1'b0;
            stall_left = pick_gap();
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_item(logic k_in, logic [31:0] x, logic [31:0] y,
                             logic [TAG_W-1:0] t, bit typed, result_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k_in;
        pos_x <= x;
        pos_y <= y;
        tag <= t;
        do @(posedge clk); while (!in_ready);
        if (typed)
        begin
            scratch.delete();
            cluster_point(k_in, x, y, t, scratch);
            pending_results.push_back(want);
        end
        else
            cluster_point(k_in, x, y, t, pending_results);
    endtask

    // drain, then hold off before touching the register
    task automatic write_radius(logic [31:0] value);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_RADIUS;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_radius = value[23:0];
    endtask

    task automatic random_point(logic [31:0] r, logic [31:0] cx, logic [31:0] cy);
        longint x, y;
        int span;
        span = (r > 32'h0FFF_FFFF) ? 32'h3FFF_FFFF : int'(3 * r);
        x = longint'(cx) + $urandom_range(0, span) - span / 2;
        y = longint'(cy) + $urandom_range(0, span) - span / 2;
        if (x < 0) x = 0;
        if (y < 0) y = 0;
        if (x > 64'hFFFF_FFFF) x = 64'hFFFF_FFFF;
        if (y > 64'hFFFF_FFFF) y = 64'hFFFF_FFFF;
        send_item(KIND_POINT, x[31:0], y[31:0], TAG_W'($urandom), 1'b0, '0);
    endtask

    initial
    begin
        row_t rows[$];
        row_t rw;
        result_t want;
        logic [31:0] seeds_x[6], seeds_y[6], rad, b;
        int s;

        cfg_radius = 24'd10240;
        n_clusters = 0;
        n_cells = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rw = '{0, KIND_FLUSH, 0, 0, 0, 1, ST_EMPTY, 0, 0};                rows.push_back(rw);
        rw = '{0, KIND_POINT, 0, 0, 31'h7FFF_FFFF, 1, ST_NEW, 0, 1};      rows.push_back(rw);
        rw = '{0, KIND_POINT, 0, 0, 0, 1, ST_JOINED, 0, 2};               rows.push_back(rw);
        rw = '{0, KIND_POINT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, ST_NEW, 1, 1};
        rows.push_back(rw);
        rw = '{0, KIND_POINT, 32'hFFFF_FFFF, 0, 2, 0, ST_NEW, 0, 0};      rows.push_back(rw);
        rw = '{0, KIND_POINT, 0, 32'hFFFF_FFFF, 3, 0, ST_NEW, 0, 0};      rows.push_back(rw);
        rw = '{0, KIND_POINT, 10240, 10240, 4, 0, ST_NEW, 0, 0};          rows.push_back(rw);
        rw = '{0, KIND_POINT, 10240, 0, 5, 0, ST_NEW, 0, 0};              rows.push_back(rw);
        rw = '{0, KIND_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 0, ST_NEW, 0, 0};
        rows.push_back(rw);
        rw = '{0, KIND_FLUSH, 0, 0, 0, 1, ST_EMPTY, 0, 0};                rows.push_back(rw);
        // radius zero behaves as one
        rw = '{1, KIND_POINT, 0, 0, 0, 0, ST_NEW, 0, 0};                  rows.push_back(rw);
        rw = '{0, KIND_POINT, 5, 5, 6, 1, ST_NEW, 0, 1};                  rows.push_back(rw);
        rw = '{0, KIND_POINT, 6, 5, 7, 1, ST_JOINED, 0, 2};               rows.push_back(rw);
        rw = '{0, KIND_POINT, 8, 5, 8, 0, ST_NEW, 0, 0};                  rows.push_back(rw);
        rw = '{0, KIND_FLUSH, 0, 0, 0, 0, ST_NEW, 0, 0};                  rows.push_back(rw);
        rw = '{1, KIND_POINT, 32'h00FF_FFFF, 0, 0, 0, ST_NEW, 0, 0};      rows.push_back(rw);
        rw = '{0, KIND_POINT, 32'hAAAA_AAAA, 32'h5555_5555, 9, 1, ST_NEW, 0, 1};
        rows.push_back(rw);
        rw = '{0, KIND_POINT, 32'hAAAB_0000, 32'h5556_0000, 10, 0, ST_NEW, 0, 0};
        rows.push_back(rw);
        rw = '{0, KIND_POINT, 32'h1234_5678, 32'hFEDC_BA98, 11, 0, ST_NEW, 0, 0};
        rows.push_back(rw);
        rw = '{0, KIND_FLUSH, 0, 0, 0, 0, ST_NEW, 0, 0};                  rows.push_back(rw);

        foreach (rows[i])
        begin
            if (rows[i].wr)
                write_radius(rows[i].x);
            else
            begin
                want = mk(rows[i].st, rows[i].id, (rows[i].kind == KIND_FLUSH) ? '0 : rows[i].t,
                          '0, '0, rows[i].cnt, 1'b1);
                send_item(rows[i].kind, rows[i].x, rows[i].y, rows[i].t, rows[i].typed, want);
            end
        end

        // random phases over several radii
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: rad = 32'd1;
                1: rad = 32'h00FF_FFFF;
                2: rad = $urandom_range(16, 4096);
                3: rad = 32'd10240;
                default: rad = $urandom_range(1, 32'h00FF_FFFF);
            endcase
            write_radius(rad);
            calm = (ph == 3);
            foreach (seeds_x[i])
            begin
                seeds_x[i] = $urandom;
                seeds_y[i] = $urandom;
            end
            seeds_x[0] = 0;
            seeds_y[1] = 32'hFFFF_FFFF;
            for (int n = 0; n < 5; n++)
            begin
                s = $urandom_range(0, 99);
                if (s < 7)
                    send_item(KIND_FLUSH, $urandom, $urandom, TAG_W'($urandom), 1'b0, '0);
                else if (s < 15)
                    send_item(KIND_POINT, $urandom, $urandom, TAG_W'($urandom), 1'b0, '0);
                else
                    random_point(rad, seeds_x[s % 6], seeds_y[s % 6]);
            end
            send_item(KIND_FLUSH, 0, 0, 0, 1'b0, '0);
        end
        calm = 1'b0;

        // fill the cluster table with one cell per cluster, then overflow
        write_radius(32'd8);
        for (int c = 0; c < MAX_CLUSTERS; c++)
        begin
            b = 32'(c * 64 + 64);
            send_item(KIND_POINT, b, b, TAG_W'(c), 1'b0, '0);
        end
        send_item(KIND_POINT, 32'h0010_0000, 32'h0010_0000, 31'h1234, 1'b0, '0);
        send_item(KIND_POINT, 32'd65, 32'd63, 31'h4321, 1'b0, '0);
        send_item(KIND_POINT, 32'd40, 32'd64, 31'h5555, 1'b0, '0);
        send_item(KIND_FLUSH, 0, 0, 0, 1'b0, '0);

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("greedy_grid_point_clusterer_tb OK");
        else
            $display("greedy_grid_point_clusterer_tb NOT OK");
        $finish;
    end

    initial
    begin
        #100000000;
        $display("greedy_grid_point_clusterer_tb NOT OK");
        $finish;
    end

endmodule

/* greedy_grid_point_clusterer.f */
hdl/ggpc_pkg.sv
hdl/ggpc_ram.sv
hdl/ggpc_div.sv
hdl/ggpc_queue.sv
hdl/ggpc_front.sv
hdl/ggpc_back.sv
hdl/greedy_grid_point_clusterer.sv
verif/greedy_grid_point_clusterer_tb.sv
